### hdl/nco_pkg.sv
// Shared types, constants and the arctangent table for the sine/cosine oscillator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nco_pkg;

    localparam int PHASE_BITS_DEF    = 32;
    localparam int OUT_BITS_DEF      = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int CORDIC_W    = 34;
    localparam int CORDIC_GAIN = 652032874;

    localparam int APB_ADDR_BITS = 3;
    localparam logic [APB_ADDR_BITS-1:0] REG_PHASE_STEP = 3'd0;

    localparam logic [1:0] OP_SIN_ADV = 2'd0;
    localparam logic [1:0] OP_COS_ADV = 2'd1;
    localparam logic [1:0] OP_SIN_MUL = 2'd2;
    localparam logic [1:0] OP_COS_MUL = 2'd3;

    typedef struct packed {
        logic                        want_cos;
        logic [1:0]                  quad;
        logic signed [CORDIC_W-1:0]  x;
        logic signed [CORDIC_W-1:0]  y;
        logic signed [CORDIC_W-1:0]  z;
    } cordic_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/nco_if.sv
// Valid/ready channel interfaces for operation requests and wave samples.
// Depends on nco_pkg for the default sample width.
`timescale 1ns / 1ps
`default_nettype none

interface nco_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] harmonic_factor;

    modport source (output valid, operation, harmonic_factor, input ready);
    modport sink   (input valid, operation, harmonic_factor, output ready);
endinterface

interface nco_out_if
    import nco_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] wave_value;

    modport source (output valid, wave_value, input ready);
    modport sink   (input valid, wave_value, output ready);
endinterface

`default_nettype wire

### hdl/nco_front.sv
// Front stage: APB register, phase accumulator, harmonic multiply and CORDIC seed.
// Depends on nco_pkg and nco_in_if.
`timescale 1ns / 1ps
`default_nettype none

module nco_front
    import nco_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    nco_in_if.sink                        in_item,
    input  wire logic                     load,
    output logic                          seed_valid,
    output cordic_t                       seed,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int PROD_W = PHASE_BITS + 16;

    logic [31:0]            step_reg;
    logic [PHASE_BITS-1:0]  step_eff;
    logic [PHASE_BITS-1:0]  acc_reg;
    logic [PHASE_BITS-1:0]  acc_next;
    logic [PROD_W-1:0]      product;
    logic [PHASE_BITS-1:0]  phase_next;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic                   cos_next;
    logic                   cos_reg;
    logic                   valid_reg;
    logic                   accept;
    logic                   advance;
    logic                   multiply;
    logic [31:0]            angle;

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_PHASE_STEP) ? step_reg : 32'd0;
    assign step_eff = PHASE_BITS'(step_reg);

    assign in_item.ready = load;
    assign accept   = in_item.valid && load;
    assign advance  = (in_item.operation == OP_SIN_ADV) || (in_item.operation == OP_COS_ADV);
    assign multiply = (in_item.operation == OP_SIN_MUL) || (in_item.operation == OP_COS_MUL);
    assign cos_next = (in_item.operation == OP_COS_ADV) || (in_item.operation == OP_COS_MUL);

    assign product    = PROD_W'(acc_reg) * PROD_W'(in_item.harmonic_factor);
    assign phase_next = multiply ? product[PHASE_BITS+11:12] : acc_reg;
    assign acc_next   = (accept && advance) ? acc_reg + step_eff : acc_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg  <= 32'd0;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            if (psel && penable && pwrite && pready && (paddr == REG_PHASE_STEP)) begin
                step_reg <= pwdata;
            end
            acc_reg <= acc_next;
            if (load) begin
                valid_reg <= in_item.valid;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            phase_reg <= phase_next;
            cos_reg   <= cos_next;
        end
    end

    generate
        if (PHASE_BITS >= 32) begin : g_angle_down
            assign angle = phase_reg[PHASE_BITS-1 -: 32];
        end
        else begin : g_angle_up
            assign angle = 32'(phase_reg) << (32 - PHASE_BITS);
        end
    endgenerate

    assign seed_valid    = valid_reg;
    assign seed.want_cos = cos_reg;
    assign seed.quad     = angle[31:30];
    assign seed.x        = CORDIC_W'(CORDIC_GAIN);
    assign seed.y        = '0;
    assign seed.z        = signed'({{(CORDIC_W-30){1'b0}}, angle[29:0]});

    a_mul_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && multiply |=> $stable(acc_reg))
        else $error("phase moved on a multiplied-phase transaction");

    a_adv_adds_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && advance |=> acc_reg == PHASE_BITS'($past(acc_reg) + $past(step_eff)))
        else $error("phase did not advance by the step");

endmodule

`default_nettype wire

### hdl/nco_cell.sv
// One CORDIC rotation cell: a registered micro-rotation by atan(2^-IDX).
// Depends on nco_pkg for the stage type and arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module nco_cell
    import nco_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire logic    valid_in,
    input  wire cordic_t data_in,
    output logic         valid_out,
    output cordic_t      data_out
);

    localparam logic signed [CORDIC_W-1:0] ATAN =
        signed'({{(CORDIC_W-32){1'b0}}, atan_turn(IDX)});

    logic                        valid_reg;
    cordic_t                     data_reg;
    cordic_t                     data_next;
    logic signed [CORDIC_W-1:0]  x_sh;
    logic signed [CORDIC_W-1:0]  y_sh;

    assign x_sh = data_in.x >>> IDX;
    assign y_sh = data_in.y >>> IDX;

    always_comb
    begin
        data_next = data_in;
        if (!data_in.z[CORDIC_W-1]) begin
            data_next.x = data_in.x - y_sh;
            data_next.y = data_in.y + x_sh;
            data_next.z = data_in.z - ATAN;
        end
        else begin
            data_next.x = data_in.x + y_sh;
            data_next.y = data_in.y - x_sh;
            data_next.z = data_in.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (load) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk) begin
        if (load && valid_in) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

### hdl/nco_back.sv
// Output stage: quadrant fold, rounding, saturation and the output register.
// Depends on nco_pkg and nco_out_if.
`timescale 1ns / 1ps
`default_nettype none

module nco_back
    import nco_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    valid_in,
    input  wire cordic_t data_in,
    output logic         load,
    nco_out_if.source    out_item
);

    localparam int SH = 31 - OUT_BITS;
    localparam int SW = CORDIC_W + 1;
    localparam logic signed [SW-1:0] RND     = SW'(1) <<< (SH - 1);
    localparam logic signed [SW-1:0] OUT_MAX = SW'((64'd1 << (OUT_BITS - 1)) - 64'd1);

    logic signed [CORDIC_W-1:0]  c_val;
    logic signed [CORDIC_W-1:0]  s_val;
    logic signed [CORDIC_W-1:0]  pick;
    logic signed [SW-1:0]        rounded;
    logic signed [SW-1:0]        shifted;
    logic signed [OUT_BITS-1:0]  wave_next;
    logic signed [OUT_BITS-1:0]  wave_reg;
    logic                        valid_reg;

    always_comb
    begin
        case (data_in.quad)
            2'd0:
            begin
                c_val = data_in.x;
                s_val = data_in.y;
            end
            2'd1:
            begin
                c_val = -data_in.y;
                s_val = data_in.x;
            end
            2'd2:
            begin
                c_val = -data_in.x;
                s_val = -data_in.y;
            end
            default:
            begin
                c_val = data_in.y;
                s_val = -data_in.x;
            end
        endcase
    end

    assign pick    = data_in.want_cos ? c_val : s_val;
    assign rounded = SW'(pick) + RND;
    assign shifted = rounded >>> SH;

    always_comb
    begin
        if (shifted > OUT_MAX) begin
            wave_next = OUT_BITS'(OUT_MAX);
        end
        else if (shifted < -OUT_MAX) begin
            wave_next = OUT_BITS'(-OUT_MAX);
        end
        else begin
            wave_next = OUT_BITS'(shifted);
        end
    end

    assign load = !valid_reg || out_item.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (load) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk) begin
        if (load && valid_in) begin
            wave_reg <= wave_next;
        end
    end

    assign out_item.valid      = valid_reg;
    assign out_item.wave_value = wave_reg;

endmodule

`default_nettype wire

### hdl/nco_sine_cosine.sv
// Sine/cosine oscillator: one transaction per clock unless the output stalls; an accepted
// transaction passes the front register, one register per CORDIC cell and the output register.
// Each stage stalls only when the stage after it is full and stalled, so
// input ready drops only while every stage holds a result and the output is not taken. The
// phase_step register sits at APB address 0 and may be rewritten only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module nco_sine_cosine
    import nco_pkg::*;
#(
    parameter int PHASE_BITS    = PHASE_BITS_DEF,
    parameter int OUT_BITS      = OUT_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    nco_in_if.sink                        in_item,
    nco_out_if.source                     out_item,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic    vld  [0:CORDIC_STAGES];
    cordic_t data [0:CORDIC_STAGES];
    logic    ld   [0:CORDIC_STAGES+1];

    nco_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .load       (ld[0]),
        .seed_valid (vld[0]),
        .seed       (data[0]),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    genvar k;
    generate
        for (k = 0; k < CORDIC_STAGES; k++) begin : g_cell
            nco_cell #(
                .IDX (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (ld[k+1]),
                .valid_in  (vld[k]),
                .data_in   (data[k]),
                .valid_out (vld[k+1]),
                .data_out  (data[k+1])
            );
        end
        for (k = 0; k <= CORDIC_STAGES; k++) begin : g_load
            assign ld[k] = !vld[k] || ld[k+1];
        end
    endgenerate

    nco_back #(
        .OUT_BITS (OUT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (vld[CORDIC_STAGES]),
        .data_in  (data[CORDIC_STAGES]),
        .load     (ld[CORDIC_STAGES+1]),
        .out_item (out_item)
    );

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_item.ready |-> out_item.valid && !out_item.ready)
        else $error("input stalled while the output was free");

    a_output_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> out_item.wave_value != {1'b1, {(OUT_BITS-1){1'b0}}})
        else $error("sample left the symmetric range");

endmodule

`default_nettype wire
